>>> src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W     = 64;
    localparam int VALUE_BITS  = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int CHAR_W      = 6;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = 16;
    localparam int BIT_CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [3:0] digit_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_DABBLE = 2'd2,
        OP_SHIFT  = 2'd3
    } cell_op_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_TRIM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

>>> src/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell
// One decimal digit of the converter chain: shift-add-3 step, digit move, clear or hold.
// ----------------------------------------------------------------------------
module b2da_cell (
    input  logic              clk,
    input  b2da_pkg::cell_op_t op,
    input  logic              bit_in,
    input  b2da_pkg::digit_t  digit_in,
    output logic              carry_out,
    output b2da_pkg::digit_t  digit_out
);
    import b2da_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    always_comb
    begin
        unique case (op)
            OP_HOLD:   digit_next = digit_reg;
            OP_CLEAR:  digit_next = '0;
            OP_DABBLE: digit_next = {adj[2:0], bit_in};
            OP_SHIFT:  digit_next = digit_in;
            default:   digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign carry_out = adj[3];
    assign digit_out = digit_reg;

endmodule

>>> src/binary_to_decimal_ascii.sv
// A value is shifted into the digit chain bit by bit, most significant bit first, and then
// each suppressed leading zero is shifted out of the top digit before its first character
// is valid. Characters then leave one per cycle while m_tready holds.
// A new value is taken only after the last character of the previous one has left.
// Reset (rst_n low, asynchronous) returns the controller to idle; digits are not cleared.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to decimal ASCII characters, most
// significant first, through a chain of shift-add-3 digit cells.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [b2da_pkg::VALUE_W-1:0]        s_tdata,  // [63:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [b2da_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [5:0] digit_char, [10:6] digit_count
    output logic                                m_tlast   // last_digit
);
    import b2da_pkg::*;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic                   ovf_reg, ovf_next;

    cell_op_t               cell_op;
    logic   [MAX_DIGITS-1:0] carry;
    digit_t [MAX_DIGITS-1:0] digit;
    digit_t                 top_digit;

    assign top_digit = digit[MAX_DIGITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++)
        begin : g_cell
            logic   cell_bit;
            digit_t cell_digit;
            if (gi == 0)
            begin : g_first
                assign cell_bit   = value_reg[VALUE_BITS-1];
                assign cell_digit = '0;
            end
            else
            begin : g_rest
                assign cell_bit   = carry[gi-1];
                assign cell_digit = digit[gi-1];
            end
            b2da_cell u_cell (
                .clk       (clk),
                .op        (cell_op),
                .bit_in    (cell_bit),
                .digit_in  (cell_digit),
                .carry_out (carry[gi]),
                .digit_out (digit[gi])
            );
        end
    endgenerate

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (rem_reg == COUNT_W'(1));
    assign m_tdata  = {{(OUT_TDATA_W - CHAR_W - COUNT_W){1'b0}}, count_reg,
                       ASCII_ZERO + CHAR_W'(top_digit)};

    always_comb
    begin
        state_next   = state_reg;
        value_next   = value_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        cell_op      = OP_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    value_next   = s_tdata[VALUE_BITS-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
                    count_next   = COUNT_W'(MAX_DIGITS);
                    ovf_next     = 1'b0;
                    cell_op      = OP_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_op    = OP_DABBLE;
                value_next = value_reg << 1;
                ovf_next   = ovf_reg | carry[MAX_DIGITS-1];
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_TRIM;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_TRIM:
            begin
                if (ovf_reg || (top_digit != '0) || (count_reg == COUNT_W'(1)))
                begin
                    rem_next   = count_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cell_op    = OP_SHIFT;
                    count_next = count_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (rem_reg == COUNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cell_op  = OP_SHIFT;
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        bit_cnt_reg <= bit_cnt_next;
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        ovf_reg     <= ovf_next;
    end

    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (top_digit <= 4'd9))
        else $error("Emitted character is not a decimal digit.");

    a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (ovf_reg || (top_digit != '0) || (count_reg == COUNT_W'(1))))
        else $error("Run starts with a leading zero.");

    a_one_side_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("New request accepted while characters are pending.");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((rem_reg != '0) && (rem_reg <= count_reg)))
        else $error("Remaining character count out of range.");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("Converter did not return to idle after the last character.");

endmodule

>>> verif/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Self-checking bench for the decimal ASCII converter. A fixed list of
// boundary values runs first, followed by random values spread over every
// digit length. Each request's characters are predicted in the bench and
// compared with every character that leaves the block, while both stream
// sides pause at random.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

    import b2da_pkg::*;

    localparam int NUM_DIRECTED = 15;
    localparam int NUM_RANDOM   = 165;
    localparam int IDLE_PCT     = 11;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] cnt;
        logic               last;
    } dec_char_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    logic                   calm     = 1'b0;
    dec_char_t              char_q[$];
    int unsigned            errors   = 0;
    int unsigned            values_sent = 0;
    int unsigned            chars_seen  = 0;
    logic [MAX_DIGITS:0]    lengths_seen = '0;

    localparam logic [63:0] DIRECTED_VALUE [NUM_DIRECTED] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'd18446744073709551615,
        64'd10000000000000000000,
        64'd9999999999999999999,
        64'd99,
        64'd100,
        64'd12345678901234567890,
        64'h8000_0000_0000_0000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0001_0000_0000,
        64'd999999999999
    };

    // An empty string means the characters come from the predictor.
    string directed_text [NUM_DIRECTED] = '{
        "0", "1", "9", "10", "18446744073709551615", "10000000000000000000",
        "9999999999999999999", "", "", "", "", "", "", "", ""
    };

    binary_to_decimal_ascii dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic predict_decimal(input logic [63:0] value);
        logic [63:0] v;
        digit_t      rev [MAX_DIGITS];
        int          n;
        dec_char_t   c;
        v = value & ({64{1'b1}} >> (64 - VALUE_BITS));
        n = 0;
        while (v != 64'd0 && n < MAX_DIGITS)
        begin
            rev[n] = digit_t'(v % 64'd10);
            v      = v / 64'd10;
            n++;
        end
        if (n == 0)
        begin
            rev[0] = '0;
            n      = 1;
        end
        for (int k = 0; k < n; k++)
        begin
            c.ch   = ASCII_ZERO + CHAR_W'(rev[n - 1 - k]);
            c.cnt  = COUNT_W'(n);
            c.last = (k == n - 1);
            char_q.push_back(c);
        end
    endtask

    function automatic logic [63:0] pick_value();
        int unsigned kind;
        int unsigned n;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] lo;
        logic [63:0] hi;
        kind = $urandom_range(0, 3);
        r    = {$urandom, $urandom};
        if (kind == 0)
            return r;
        if (kind == 1)
            return r >> $urandom_range(0, 63);
        n = $urandom_range(1, MAX_DIGITS);
        p = 64'd1;
        repeat (n - 1) p = p * 64'd10;
        lo = (n == 1) ? 64'd0 : p;
        hi = (n >= 20) ? {64{1'b1}} : p * 64'd10 - 64'd1;
        return lo + (r % (hi - lo + 64'd1));
    endfunction

    task automatic send_value(input logic [63:0] value, input string text);
        dec_char_t c;
        byte       b;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (text.len() == 0)
            predict_decimal(value);
        else
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                b      = text[i];
                c.ch   = b[CHAR_W-1:0];
                c.cnt  = COUNT_W'(text.len());
                c.last = (i == text.len() - 1);
                char_q.push_back(c);
            end
        end
        values_sent++;
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            dec_char_t want;
            dec_char_t got;
            got.ch   = m_tdata[CHAR_W-1:0];
            got.cnt  = m_tdata[CHAR_W+COUNT_W-1:CHAR_W];
            got.last = m_tlast;
            chars_seen++;
            if (char_q.size() == 0)
                note_error($sformatf("%0t: unexpected character ch=%0d cnt=%0d last=%0b",
                                     $realtime, got.ch, got.cnt, got.last));
            else
            begin
                want = char_q.pop_front();
                if (got.ch !== want.ch || got.cnt !== want.cnt || got.last !== want.last
                    || m_tdata[OUT_TDATA_W-1:CHAR_W+COUNT_W] !== '0)
                    note_error($sformatf(
                        "%0t: mismatch ch=%0d/%0d cnt=%0d/%0d last=%0b/%0b pad=%0h",
                        $realtime, got.ch, want.ch, got.cnt, want.cnt, got.last,
                        want.last, m_tdata[OUT_TDATA_W-1:CHAR_W+COUNT_W]));
                if (want.last && want.cnt <= MAX_DIGITS)
                    lengths_seen[want.cnt] = 1'b1;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(DIRECTED_VALUE[i], directed_text[i]);
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge clk);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            calm <= (i >= 60 && i < 100);
            if (i == 100)
            begin
                s_tvalid <= 1'b0;
                while (char_q.size() != 0) @(posedge clk);
            end
            send_value(pick_value(), "");
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        while (char_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Converted %0d values into %0d characters; %0d of %0d digit lengths seen.",
                 values_sent, chars_seen, $countones(lengths_seen), MAX_DIGITS);
        $display("Mismatches and stray characters: %0d.", errors);
        if (errors == 0)
            $display("binary_to_decimal_ascii_tb: done, clean");
        else
            $display("binary_to_decimal_ascii_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d characters still expected.", char_q.size());
        $display("binary_to_decimal_ascii_tb: done, errors");
        $finish;
    end

endmodule
